>>> rtl/hrevg_pkg.sv
// Package for the hold/repeat event generator: field widths, item and
// table entry layouts, sequencer states. Used by every rtl file.
package hrevg_pkg;

    localparam int IDX_W       = 6;
    localparam int PRESS_W     = 3;
    localparam int TIME_W      = 16;
    localparam int HELD_W      = 32;
    localparam int CNT_W       = 16;
    localparam int HP_W        = TIME_W + PRESS_W;
    localparam int PROD_W      = HELD_W + 1;
    localparam int K_W         = 4;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 24;
    localparam int ITEM_W      = IDX_W + PRESS_W + 1 + 3 * TIME_W;
    localparam int RESULT_LIMIT = 32;

    localparam int NUM_MAPPINGS_DEF = 64;
    localparam int MAX_BURST_DEF    = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // input item, mapping_index in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0]  repeat_time;
        logic [TIME_W-1:0]  hold_time;
        logic [TIME_W-1:0]  delta_time;
        logic               still_held;
        logic [PRESS_W-1:0] press_count;
        logic [IDX_W-1:0]   mapping_index;
    } item_t;

    // one table entry per mapping
    typedef struct packed {
        logic              holding;
        logic [HELD_W-1:0] held_time;
        logic [CNT_W-1:0]  emitted_count;
    } entry_t;

    // one event handed from the sequencer to the output register
    typedef struct packed {
        logic [IDX_W-1:0] event_mapping;
        logic [CNT_W-1:0] event_number;
        logic             last_of_step;
    } evt_t;

    typedef struct packed {
        logic clearing;
        logic mem_we;
    } ctrl_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PLAN,
        ST_PRESS,
        ST_BURST,
        ST_RELEASE,
        ST_WRITE
    } ctrl_state_t;

endpackage

>>> rtl/hrevg_mem.sv
// Per-mapping state table: one write port, one read port, registered read.
// Depends on hrevg_pkg for the entry layout.
module hrevg_mem
    import hrevg_pkg::*;
#(
    parameter int DEPTH = NUM_MAPPINGS_DEF,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem_reg [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/hrevg_ctrl.sv
// Sequencer: clears the table, reads an entry, plans the events, emits them
// one per cycle unless stalled and writes the entry back. Depends on hrevg_pkg, hrevg_mem.
module hrevg_ctrl
    import hrevg_pkg::*;
#(
    parameter int NUM_MAPPINGS = NUM_MAPPINGS_DEF,
    parameter int MAX_BURST    = MAX_BURST_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  item_t        in_item,
    output logic         evt_valid,
    output evt_t         evt,
    input  logic         out_free,
    output ctrl_status_t status
);

    localparam int AW        = (NUM_MAPPINGS > 1) ? $clog2(NUM_MAPPINGS) : 1;
    localparam int BURST_CAP = (MAX_BURST < RESULT_LIMIT) ? MAX_BURST : RESULT_LIMIT;
    localparam int BW        = $clog2(BURST_CAP + 1);

    ctrl_state_t       state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    item_t             item_reg, item_next;
    logic [HP_W-1:0]   hp_reg, hp_next;
    logic              flag_reg, flag_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HELD_W-1:0] t_reg, t_next;
    logic [HELD_W-1:0] d_reg, d_next;
    logic [PROD_W-1:0] prod_a_reg, prod_a_next;
    logic [PROD_W-1:0] prod_b_reg, prod_b_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              start_reg, start_next;
    logic              tail_reg, tail_next;
    logic [BW-1:0]     burst_reg, burst_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    entry_t            mem_wdata;
    entry_t            mem_rdata;

    logic [HELD_W:0]   held_sum;
    logic [HELD_W-1:0] cnt_mul;
    logic [HELD_W:0]   t_sub;
    logic              start_ok;
    logic              rel_first;
    logic [CNT_W-1:0]  cnt_inc;
    logic              elig_a;
    logic              elig_b;
    logic              rep_zero;

    hrevg_mem #(
        .DEPTH (NUM_MAPPINGS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (AW'(in_item.mapping_index)),
        .rdata (mem_rdata)
    );

    // datapath terms
    assign held_sum  = {1'b0, mem_rdata.held_time} + (HELD_W + 1)'(item_reg.delta_time);
    assign cnt_mul   = HELD_W'(mem_rdata.emitted_count) * HELD_W'(item_reg.repeat_time);
    assign t_sub     = {1'b0, t_reg} - (HELD_W + 1)'(item_reg.hold_time);
    assign start_ok  = HP_W'(item_reg.delta_time) >= hp_reg;
    assign rel_first = cnt_reg != '0;
    assign rep_zero  = item_reg.repeat_time == '0;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign elig_a    = (cnt_reg != COUNT_MAX)
                       && (rep_zero ? (cnt_reg == '0) : (prod_a_reg <= {1'b0, d_reg}))
                       && (32'(burst_reg) < BURST_CAP);
    assign elig_b    = (cnt_inc != COUNT_MAX) && !rep_zero
                       && (prod_b_reg <= {1'b0, d_reg})
                       && (32'(burst_reg) + 1 < BURST_CAP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        hp_reg     <= hp_next;
        flag_reg   <= flag_next;
        held_reg   <= held_next;
        cnt_reg    <= cnt_next;
        t_reg      <= t_next;
        d_reg      <= d_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        k_reg      <= k_next;
        start_reg  <= start_next;
        tail_reg   <= tail_next;
        burst_reg  <= burst_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        item_next     = item_reg;
        hp_next       = hp_reg;
        flag_next     = flag_reg;
        held_next     = held_reg;
        cnt_next      = cnt_reg;
        t_next        = t_reg;
        d_next        = d_reg;
        prod_a_next   = prod_a_reg;
        prod_b_next   = prod_b_reg;
        k_next        = k_reg;
        start_next    = start_reg;
        tail_next     = tail_reg;
        burst_next    = burst_reg;
        in_ready      = 1'b0;
        evt_valid     = 1'b0;
        evt.event_mapping = item_reg.mapping_index;
        evt.event_number  = '0;
        evt.last_of_step  = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = AW'(item_reg.mapping_index);
        mem_wdata     = {flag_reg, held_reg, cnt_reg};

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (32'(clr_addr_reg) == NUM_MAPPINGS - 1) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next = in_item;
                    hp_next   = HP_W'(in_item.hold_time) * HP_W'(in_item.press_count);
                    // drop items for mappings that do not exist
                    if (32'(in_item.mapping_index) < NUM_MAPPINGS) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                flag_next   = mem_rdata.holding;
                held_next   = mem_rdata.held_time;
                cnt_next    = mem_rdata.emitted_count;
                t_next      = held_sum[HELD_W] ? '1 : held_sum[HELD_W-1:0];
                prod_a_next = PROD_W'(cnt_mul);
                state_next  = ST_PLAN;
            end
            ST_PLAN: begin
                if (item_reg.press_count != '0) begin
                    // releases and starts alternate to end on a start; else one release
                    start_next = start_ok;
                    tail_next  = start_ok && !item_reg.still_held;
                    if (start_ok) begin
                        k_next = K_W'(rel_first) + {item_reg.press_count, 1'b0} - 1'b1;
                    end else begin
                        k_next = K_W'(rel_first);
                    end
                    if (item_reg.still_held) begin
                        flag_next = 1'b1;
                        cnt_next  = start_ok ? CNT_W'(1) : '0;
                        if (rel_first || (start_ok && item_reg.press_count > PRESS_W'(1))) begin
                            held_next = '0;
                        end
                    end else begin
                        flag_next = 1'b0;
                        held_next = '0;
                        cnt_next  = '0;
                    end
                    if (start_ok || rel_first) begin
                        state_next = ST_PRESS;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end else if (flag_reg) begin
                    if (!item_reg.still_held) begin
                        flag_next  = 1'b0;
                        held_next  = '0;
                        cnt_next   = '0;
                        state_next = rel_first ? ST_RELEASE : ST_WRITE;
                    end else begin
                        held_next   = t_reg;
                        d_next      = t_sub[HELD_W-1:0];
                        prod_b_next = prod_a_reg + PROD_W'(item_reg.repeat_time);
                        burst_next  = '0;
                        state_next  = t_sub[HELD_W] ? ST_WRITE : ST_BURST;
                    end
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_PRESS: begin
                evt_valid        = 1'b1;
                evt.event_number = (start_reg && k_reg[0]) ? CNT_W'(1) : '0;
                evt.last_of_step = (k_reg == K_W'(1)) && !tail_reg;
                if (out_free) begin
                    k_next = k_reg - 1'b1;
                    if (k_reg == K_W'(1)) begin
                        state_next = tail_reg ? ST_RELEASE : ST_WRITE;
                    end
                end
            end
            ST_BURST: begin
                if (!elig_a) begin
                    state_next = ST_WRITE;
                end else begin
                    evt_valid        = 1'b1;
                    evt.event_number = cnt_inc;
                    evt.last_of_step = !elig_b;
                    if (out_free) begin
                        cnt_next    = cnt_inc;
                        prod_a_next = prod_b_reg;
                        prod_b_next = prod_b_reg + PROD_W'(item_reg.repeat_time);
                        burst_next  = burst_reg + 1'b1;
                        if (!elig_b) begin
                            state_next = ST_WRITE;
                        end
                    end
                end
            end
            ST_RELEASE: begin
                evt_valid        = 1'b1;
                evt.event_number = '0;
                evt.last_of_step = 1'b1;
                if (out_free) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign status.clearing = state_reg == ST_CLEAR;
    assign status.mem_we   = mem_we;

endmodule

>>> rtl/hold_repeat_event_generator.sv
// Top level of the hold/repeat (typematic) event generator: stream ports,
// output register and checks. Depends on hrevg_pkg, hrevg_ctrl, hrevg_mem.
//
//   channel  direction  ports                              content
//   s_       in         s_tvalid s_tready s_tdata[63:0]    one time step of one mapping
//   m_       out        m_tvalid m_tready m_tdata[23:0]    one event, tlast on the last
//                       m_tlast                            event of its input item
//
// An item passes through accept, table read, plan and write back, plus a pass
// through the output register for each event it causes, one event per cycle
// unless m_tready stalls; a held step that finds no repeat due also passes
// through the burst state. The single table port pair keeps items apart: the
// entry is read, modified and written back before the next item is taken.
// After reset the table is cleared entry by entry; no item is
// accepted meanwhile. A stall on m_tready holds the sequencer on its current
// event; the final event may wait in the output register while the next
// item is already accepted.
module hold_repeat_event_generator
    import hrevg_pkg::*;
#(
    parameter int NUM_MAPPINGS = NUM_MAPPINGS_DEF,
    parameter int MAX_BURST    = MAX_BURST_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // mapping_index[5:0], press_count[8:6], still_held[9], delta_time[25:10],
    // hold_time[41:26], repeat_time[57:42], zero fill above
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // event_mapping[5:0], event_number[21:6], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast     // last_of_step
);

    item_t        in_item;
    logic         evt_valid;
    evt_t         evt;
    logic         out_free;
    ctrl_status_t status;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    // unpack the item; the fill bits above the fields are ignored
    assign in_item = item_t'(s_tdata[ITEM_W-1:0]);

    hrevg_ctrl #(
        .NUM_MAPPINGS (NUM_MAPPINGS),
        .MAX_BURST    (MAX_BURST)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .evt_valid (evt_valid),
        .evt       (evt),
        .out_free  (out_free),
        .status    (status)
    );

    // the output register takes a new event when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (evt_valid && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload: load with each new event, hold otherwise
    always_ff @(posedge aclk) begin
        if (evt_valid && out_free) begin
            m_tdata_reg <= M_TDATA_W'({evt.event_number, evt.event_mapping});
            m_tlast_reg <= evt.last_of_step;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // an in-range item blocks the input until its write back is done
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (32'(s_tdata[IDX_W-1:0]) < NUM_MAPPINGS)) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // a write back ends the item and reopens the input
    a_write_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.mem_we && !status.clearing) |=> s_tready)
        else $error("sequencer did not return to idle after write back");

    // no event leaves during the clearing pass
    a_no_event_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> (!m_tvalid && !evt_valid))
        else $error("event produced during table clearing");

endmodule

>>> tb/hold_repeat_event_generator_tb.sv
// Self-checking testbench for hold_repeat_event_generator: drives time steps on the s_ stream,
// predicts the hold/repeat events per mapping and checks every m_ event against that prediction.
// Depends on hrevg_pkg and the RTL under rtl/.
module hold_repeat_event_generator_tb;
    import hrevg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_MAP     = NUM_MAPPINGS_DEF;
    localparam int MAX_BURST   = MAX_BURST_DEF;
    // starts per held step never exceed the burst size or the per-item result cap
    localparam int BURST_CAP   = (MAX_BURST < RESULT_LIMIT) ? MAX_BURST : RESULT_LIMIT;
    localparam int STALL_LIMIT = 4000;   // cycles with no item moved on either channel
    localparam int TAIL_CYCLES = 60;     // settle time after the last event
    localparam int RX_HOLD_OFF = 300;    // long receiver stall to back up the block
    localparam int RANDOM_ITEMS = 370;
    // a few long held steps on one mapping
    localparam int SOAK_STEPS  = 4;

    // one expected event
    typedef struct {
        logic [IDX_W-1:0] mapping;
        logic [CNT_W-1:0] number;
        logic             last;
    } event_rec_t;

    // one row of the directed table: n_typed < 0 means "take the predictor's events"
    typedef struct {
        item_t            it;
        int               n_typed;
        logic [CNT_W-1:0] num0;
        logic [CNT_W-1:0] num1;
    } step_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // mapping_index, press_count, still_held, delta_time, hold_time, repeat_time, zero fill
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // event_mapping, event_number, zero fill
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // predictor copy of the per-mapping table
    logic                map_holding [NUM_MAP];
    logic [HELD_W-1:0]   map_held_ms [NUM_MAP];
    logic [CNT_W-1:0]    map_count   [NUM_MAP];

    // per-mapping timing used by the random part, and the mappings it favors
    logic [TIME_W-1:0]   map_hold_ms [NUM_MAP];
    logic [TIME_W-1:0]   map_rep_ms  [NUM_MAP];
    logic [IDX_W-1:0]    busy_maps   [8];

    event_rec_t step_events[$];      // events of the item being predicted
    event_rec_t pending_events[$];   // events still owed by the block
    event_rec_t want;
    step_row_t  directed[$];

    int n_mismatch   = 0;
    int quiet_cycles = 0;
    int rx_hold_req  = 0;
    int rx_gap       = 0;
    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;

    hold_repeat_event_generator #(
        .NUM_MAPPINGS (NUM_MAP),
        .MAX_BURST    (MAX_BURST)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // queue one event; anything past the per-item result cap is dropped
    function automatic void add_event(logic [IDX_W-1:0] m, logic [CNT_W-1:0] num);
        if (step_events.size() < RESULT_LIMIT)
            step_events.push_back('{m, num, 1'b0});
    endfunction

    // bump the count (sticking at its maximum) and announce it
    function automatic void fire_start(logic [IDX_W-1:0] m);
        if (map_count[m] != COUNT_MAX)
            map_count[m]++;
        add_event(m, map_count[m]);
    endfunction

    // clear the entry; only a run that produced events gets a release event
    function automatic void fire_release(logic [IDX_W-1:0] m);
        logic had_events;
        had_events = (map_count[m] != 0);
        map_held_ms[m] = '0;
        map_count[m]   = '0;
        map_holding[m] = 1'b0;
        if (had_events)
            add_event(m, '0);
    endfunction

    // advance one mapping by one time step and leave its events in step_events
    function automatic void predict_step(item_t it);
        logic [IDX_W-1:0]  m;
        int unsigned       presses;
        logic [HELD_W:0]   sum;
        logic [HELD_W-1:0] extra;
        int unsigned       target;
        int unsigned       burst;
        step_events.delete();
        m       = it.mapping_index;
        presses = it.press_count;
        // every 6-bit index is a valid mapping with 64 entries, so nothing is dropped here
        for (int p = 0; p < presses; p++) begin
            // a fresh press closes the earlier run; a run without events keeps its time
            if (map_count[m] != 0)
                fire_release(m);
            map_holding[m] = 1'b1;
            if (32'(it.delta_time) >= 32'(it.hold_time) * presses)
                fire_start(m);
        end
        if (map_holding[m]) begin
            if (!it.still_held) begin
                fire_release(m);
            end else if (presses == 0) begin
                // accumulate held time, sticking at all ones
                sum = {1'b0, map_held_ms[m]} + (HELD_W + 1)'(it.delta_time);
                map_held_ms[m] = sum[HELD_W] ? '1 : sum[HELD_W-1:0];
                if (map_held_ms[m] >= HELD_W'(it.hold_time)) begin
                    target = 1;
                    burst  = 0;
                    if (it.repeat_time != 0) begin
                        extra  = (map_held_ms[m] - HELD_W'(it.hold_time))
                                 / HELD_W'(it.repeat_time);
                        target = (extra >= HELD_W'(COUNT_MAX)) ? 32'(COUNT_MAX)
                                                               : 32'(extra) + 1;
                    end
                    // catch up, but never more than one burst per step
                    while (map_count[m] < target && burst < BURST_CAP) begin
                        fire_start(m);
                        burst++;
                    end
                end
            end
        end
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic item_t mk_item(int m, int p, int s, int d, int h, int r);
        item_t it;
        it.mapping_index = IDX_W'(m);
        it.press_count   = PRESS_W'(p);
        it.still_held    = s[0];
        it.delta_time    = TIME_W'(d);
        it.hold_time     = TIME_W'(h);
        it.repeat_time   = TIME_W'(r);
        return it;
    endfunction

    function automatic step_row_t mk_row(int m, int p, int s, int d, int h, int r,
                                         int n = -1, int a = 0, int b = 0);
        step_row_t row;
        row.it      = mk_item(m, p, s, d, h, r);
        row.n_typed = n;
        row.num0    = CNT_W'(a);
        row.num1    = CNT_W'(b);
        return row;
    endfunction

    // mostly hold/repeat steps on a few busy mappings, with some noise on all fields
    function automatic item_t random_step();
        item_t it;
        int    pick;
        if ($urandom_range(0, 9) == 0)
            it.mapping_index = IDX_W'($urandom);
        else
            it.mapping_index = busy_maps[$urandom_range(0, 7)];
        pick = $urandom_range(0, 99);
        if (pick < 65)
            it.press_count = '0;
        else if (pick < 88)
            it.press_count = PRESS_W'(1);
        else
            it.press_count = PRESS_W'($urandom_range(0, 7));
        it.still_held = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 7) == 0)
            it.delta_time = TIME_W'($urandom);
        else
            it.delta_time = TIME_W'($urandom_range(0, 120));
        if ($urandom_range(0, 7) == 0) begin
            it.hold_time   = TIME_W'($urandom);
            it.repeat_time = TIME_W'($urandom);
        end else begin
            it.hold_time   = map_hold_ms[it.mapping_index];
            it.repeat_time = map_rep_ms[it.mapping_index];
        end
        return it;
    endfunction

    // Offer one item and record its events once it is taken. Call at a falling edge;
    // returns at a falling edge with s_tvalid still high.
    task automatic send_step(input item_t it, input int n_typed = -1,
                             input logic [CNT_W-1:0] num0 = '0,
                             input logic [CNT_W-1:0] num1 = '0);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(it);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_step(it);
        // directed rows with results typed in replace the predicted events
        if (n_typed >= 0) begin
            step_events.delete();
            if (n_typed > 0)
                step_events.push_back('{it.mapping_index, num0, n_typed == 1});
            if (n_typed > 1)
                step_events.push_back('{it.mapping_index, num1, 1'b1});
        end
        foreach (step_events[i])
            pending_events.push_back(step_events[i]);
        @(negedge aclk);
    endtask

    // drop valid and hold off until every owed event has come out
    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void flag_mismatch(string what);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    // ---------------------------------------------------------------- receiver

    // Drive m_tready at the falling edge: a requested long hold-off first, else short
    // random stalls when enabled, else ready.
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_req != 0) begin
                rx_gap      = rx_hold_req;
                rx_hold_req = 0;
            end else if (rx_gap == 0 && rx_idle_en && $urandom_range(0, 4) == 0) begin
                rx_gap = $urandom_range(1, 3);
            end
            if (rx_gap != 0) begin
                m_tready <= 1'b0;
                rx_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- checker

    // Compare each event taken at a rising edge with the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                flag_mismatch($sformatf("unexpected event: mapping %0d number %0d last %0b",
                              m_tdata[IDX_W-1:0], m_tdata[IDX_W+CNT_W-1:IDX_W], m_tlast));
            end else begin
                want = pending_events.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.mapping
                        || m_tdata[IDX_W+CNT_W-1:IDX_W] !== want.number
                        || m_tlast !== want.last)
                    flag_mismatch($sformatf(
                        "event mismatch: expected mapping %0d number %0d last %0b, got %0d %0d %0b",
                        want.mapping, want.number, want.last, m_tdata[IDX_W-1:0],
                        m_tdata[IDX_W+CNT_W-1:IDX_W], m_tlast));
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("hold_repeat_event_generator test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        for (int i = 0; i < NUM_MAP; i++) begin
            map_holding[i] = 1'b0;
            map_held_ms[i] = '0;
            map_count[i]   = '0;
            map_hold_ms[i] = TIME_W'($urandom_range(0, 300));
            map_rep_ms[i]  = ($urandom_range(0, 4) == 0) ? '0 : TIME_W'($urandom_range(1, 80));
        end
        // keep both index extremes among the busy mappings
        busy_maps[0] = '0;
        busy_maps[1] = '1;
        for (int i = 2; i < 8; i++)
            busy_maps[i] = IDX_W'($urandom);

        // Directed table: fresh presses, presses without a start, holds, repeats,
        // catch-up bursts, releases with and without events.
        directed = '{
            // first press after reset with zero hold time starts at once
            mk_row(0,  1, 1, 0,     0,     0,     1, 1),
            mk_row(0,  0, 1, 100,   0,     0),
            mk_row(0,  0, 0, 0,     0,     0,     1, 0),
            // seven presses, hold time too long for an immediate start
            mk_row(63, 7, 1, 65535, 65535, 65535, 0),
            mk_row(63, 0, 1, 65535, 65535, 65535),
            // fresh press closes the run, then starts again
            mk_row(63, 1, 1, 65535, 0,     65535, 2, 0, 1),
            mk_row(63, 0, 0, 65535, 65535, 65535, 1, 0),
            // press while holding without events keeps the held time
            mk_row(5,  1, 1, 10,    100,   50),
            mk_row(5,  0, 1, 60,    100,   50),
            mk_row(5,  1, 1, 20,    100,   50),
            mk_row(5,  0, 1, 40,    100,   50),
            mk_row(5,  0, 1, 50,    100,   50),
            mk_row(5,  0, 0, 0,     100,   50,    1, 0),
            // catch-up: one full burst per step, more on the next step
            mk_row(7,  1, 1, 0,     0,     1),
            mk_row(7,  0, 1, 65535, 0,     1),
            mk_row(7,  0, 1, 0,     0,     1),
            mk_row(7,  0, 0, 0,     0,     1),
            // several presses in one step, then presses with a let-go
            mk_row(9,  3, 1, 300,   100,   0),
            mk_row(9,  2, 0, 0,     0,     0),
            // held but never pressed: nothing happens
            mk_row(20, 0, 1, 500,   0,     0,     0),
            // let go of a run that never fired: no release event
            mk_row(30, 1, 1, 0,     10,    0),
            mk_row(30, 0, 0, 0,     10,    0,     0),
            // repeat time zero: one start, no repeats
            mk_row(11, 1, 1, 0,     50,    0),
            mk_row(11, 0, 1, 65535, 50,    0),
            mk_row(11, 0, 1, 65535, 50,    0)
        };

        // hold reset, then release it between edges
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i])
            send_step(directed[i].it, directed[i].n_typed, directed[i].num0, directed[i].num1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // back the block up: stall the receiver while items keep coming
            if (i == 150)
                rx_hold_req = RX_HOLD_OFF;
            // pause the sender until the block has nothing left to say
            if (i == 250)
                drain_events();
            // run the tail of the random part, and everything after, without idling
            if (i == RANDOM_ITEMS - 50) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            send_step(random_step());
        end

        // Soak one mapping: a few 65535 ms held steps, each one firing a single repeat,
        // then a let-go.
        send_step(mk_item(40, 0, 0, 0, 0, 65535));
        send_step(mk_item(40, 1, 1, 0, 0, 65535));
        for (int k = 0; k < SOAK_STEPS; k++)
            send_step(mk_item(40, 0, 1, 65535, 0, 65535));
        send_step(mk_item(40, 0, 0, 0, 0, 65535));

        drain_events();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (n_mismatch == 0 && pending_events.size() == 0)
            $display("hold_repeat_event_generator test passed");
        else
            $display("hold_repeat_event_generator test failed");
        $finish;
    end

endmodule
